// ===== design/tbct_pkg.sv =====
// Package for the track boundary cosmic tagger.
// Holds register indexes, face and tag codes, and the tag/score classifier.
// No dependencies.
`timescale 1ns / 1ps

package tbct_pkg;

  // Configuration registers: width and index codes
  localparam int REG_BITS = 19;
  localparam int CFG_IDX_BITS = 3;

  typedef logic [REG_BITS-1:0]     reg_t;
  typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_DET_WIDTH       = 3'd0;
  localparam cfg_idx_t CFG_DET_HALF_HEIGHT = 3'd1;
  localparam cfg_idx_t CFG_DET_LENGTH      = 3'd2;
  localparam cfg_idx_t CFG_X_MARGIN        = 3'd3;
  localparam cfg_idx_t CFG_Y_MARGIN        = 3'd4;
  localparam cfg_idx_t CFG_Z_MARGIN        = 3'd5;

  localparam reg_t RST_DET_WIDTH       = 19'd16406;
  localparam reg_t RST_DET_HALF_HEIGHT = 19'd7456;
  localparam reg_t RST_DET_LENGTH      = 19'd66355;
  localparam reg_t RST_MARGIN          = 19'd320;

  // Face code of one endpoint, compacted: one bit per detector face
  typedef logic [5:0] face_t;

  localparam int FACE_X_HI = 0;  // near x = det_width
  localparam int FACE_X_LO = 1;  // near x = 0
  localparam int FACE_Y_HI = 2;  // near top face
  localparam int FACE_Y_LO = 3;  // near bottom face
  localparam int FACE_Z_HI = 4;  // near z = det_length
  localparam int FACE_Z_LO = 5;  // near z = 0

  // Result codes
  typedef logic [3:0] tag_t;
  typedef logic [3:0] score_t;

  localparam tag_t TAG_NONE = 4'd0;
  localparam tag_t TAG_X    = 4'd1;
  localparam tag_t TAG_Y    = 4'd2;
  localparam tag_t TAG_Z    = 4'd3;
  localparam tag_t TAG_XX   = 4'd4;
  localparam tag_t TAG_YY   = 4'd5;
  localparam tag_t TAG_ZZ   = 4'd6;
  localparam tag_t TAG_XY   = 4'd7;
  localparam tag_t TAG_XZ   = 4'd8;
  localparam tag_t TAG_YZ   = 4'd9;

  localparam score_t SCORE_NONE   = 4'd0;
  localparam score_t SCORE_ZZ     = 4'd4;
  localparam score_t SCORE_SINGLE = 4'd5;
  localparam score_t SCORE_PAIR   = 4'd10;

  typedef struct packed {
    tag_t   tag;
    score_t score;
  } result_t;

  // Tag and score from the OR of both endpoint face codes
  function automatic result_t classify(input face_t m);
    result_t  res;
    logic     has_x;
    logic     has_y;
    logic     has_z;
    logic [2:0] bits;
    has_x = m[FACE_X_HI] | m[FACE_X_LO];
    has_y = m[FACE_Y_HI] | m[FACE_Y_LO];
    has_z = m[FACE_Z_HI] | m[FACE_Z_LO];
    bits = '0;
    for (int i = 0; i < 6; i++) begin
      bits = bits + {2'b00, m[i]};
    end
    res.tag   = TAG_NONE;
    res.score = SCORE_NONE;
    if (bits > 3'd1) begin
      if (!(m[FACE_Z_HI] && m[FACE_Z_LO])) begin
        res.score = SCORE_PAIR;
        if (m[FACE_X_HI] && m[FACE_X_LO])      res.tag = TAG_XX;
        else if (m[FACE_Y_HI] && m[FACE_Y_LO]) res.tag = TAG_YY;
        else if (has_x && has_y)               res.tag = TAG_XY;
        else if (has_x && has_z)               res.tag = TAG_XZ;
        else                                   res.tag = TAG_YZ;
      end else begin
        res.tag   = TAG_ZZ;
        res.score = SCORE_ZZ;
      end
    end else if (bits == 3'd1) begin
      res.score = SCORE_SINGLE;
      if (has_x)      res.tag = TAG_X;
      else if (has_y) res.tag = TAG_Y;
      else            res.tag = TAG_Z;
    end
    return res;
  endfunction

endpackage

// ===== design/track_boundary_cosmic_tagger.sv =====
// Track boundary cosmic tagger, top level.
// Tracks the highest and lowest point of an object and tags boundary contact.
// Depends on tbct_pkg.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_*): one space point per transaction. in_last_point marks
//   the final point of an object; in_no_points ends an empty object, whose
//   coordinates are ignored. Only transactions carrying either flag produce
//   a result on the output channel (out_*): a tag code and a score in tenths.
//   Configuration (cfg_*): det_width, det_half_height, det_length and the
//   three margins, written by index while no object is in flight.
// Timing
//   One transaction per cycle is accepted while in_stall is low. The edge that
//   accepts the final point updates the endpoint trackers and latches the
//   endpoints into stage 1; stage 2 then classifies them against the detector
//   faces into the output register once it is free, and out_valid rises.
// Reset and stall
//   Reset clears the trackers and both stages' valid flags, restores default geometry.
//   When the receiver stalls, the output register holds; the input keeps being
//   accepted until stage 1 also holds a result, then in_stall rises.
module track_boundary_cosmic_tagger #(
  parameter int COORD_BITS = 20
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_BITS-1:0]  in_point_x,
  input  logic signed [COORD_BITS-1:0]  in_point_y,
  input  logic signed [COORD_BITS-1:0]  in_point_z,
  input  logic                          in_last_point,
  input  logic                          in_no_points,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output tbct_pkg::tag_t                out_tag_code,
  output tbct_pkg::score_t              out_score_tenths,
  // configuration port
  input  logic                          cfg_we,
  input  tbct_pkg::cfg_idx_t            cfg_index,
  input  tbct_pkg::reg_t                cfg_wdata
);
  import tbct_pkg::*;

  // compare width: the wider of coordinate and register width, plus a sign bit and a carry
  localparam int CMP_W = ((COORD_BITS > REG_BITS) ? COORD_BITS : REG_BITS) + 2;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [CMP_W-1:0]      cmp_t;

  // Configuration registers
  reg_t det_width_r, det_half_height_r, det_length_r;
  reg_t x_margin_r, y_margin_r, z_margin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      det_width_r       <= RST_DET_WIDTH;
      det_half_height_r <= RST_DET_HALF_HEIGHT;
      det_length_r      <= RST_DET_LENGTH;
      x_margin_r        <= RST_MARGIN;
      y_margin_r        <= RST_MARGIN;
      z_margin_r        <= RST_MARGIN;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DET_WIDTH:       det_width_r       <= cfg_wdata;
        CFG_DET_HALF_HEIGHT: det_half_height_r <= cfg_wdata;
        CFG_DET_LENGTH:      det_length_r      <= cfg_wdata;
        CFG_X_MARGIN:        x_margin_r        <= cfg_wdata;
        CFG_Y_MARGIN:        y_margin_r        <= cfg_wdata;
        CFG_Z_MARGIN:        z_margin_r        <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Handshake and stage control
  logic s1_valid_r, s1_valid_nxt;
  logic s1_empty_r;
  logic out_valid_r, out_valid_nxt;
  logic out_adv;
  logic in_accept;
  logic obj_end;

  assign out_adv   = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !out_adv;
  assign in_accept = in_valid && !in_stall;
  assign obj_end   = in_last_point || in_no_points;

  // Endpoint trackers
  coord_t top_x_r, top_y_r, top_z_r;
  coord_t bot_x_r, bot_y_r, bot_z_r;
  coord_t top_x_nxt, top_y_nxt, top_z_nxt;
  coord_t bot_x_nxt, bot_y_nxt, bot_z_nxt;
  logic   have_point_r, have_point_nxt;

  always_comb begin
    top_x_nxt = top_x_r;
    top_y_nxt = top_y_r;
    top_z_nxt = top_z_r;
    bot_x_nxt = bot_x_r;
    bot_y_nxt = bot_y_r;
    bot_z_nxt = bot_z_r;
    // first point seeds both ends; ties keep the earlier point
    if (!have_point_r || in_point_y > top_y_r) begin
      top_x_nxt = in_point_x;
      top_y_nxt = in_point_y;
      top_z_nxt = in_point_z;
    end
    if (!have_point_r || in_point_y < bot_y_r) begin
      bot_x_nxt = in_point_x;
      bot_y_nxt = in_point_y;
      bot_z_nxt = in_point_z;
    end
  end

  always_comb begin
    have_point_nxt = have_point_r;
    if (in_accept) have_point_nxt = !obj_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_point_r <= 1'b0;
      top_x_r      <= '0;
      top_y_r      <= '0;
      top_z_r      <= '0;
      bot_x_r      <= '0;
      bot_y_r      <= '0;
      bot_z_r      <= '0;
    end else begin
      have_point_r <= have_point_nxt;
      if (in_accept && !in_no_points) begin
        top_x_r <= top_x_nxt;
        top_y_r <= top_y_nxt;
        top_z_r <= top_z_nxt;
        bot_x_r <= bot_x_nxt;
        bot_y_r <= bot_y_nxt;
        bot_z_r <= bot_z_nxt;
      end
    end
  end

  // Stage 1: endpoints of a finished object
  coord_t s1_top_x_r, s1_top_y_r, s1_top_z_r;
  coord_t s1_bot_x_r, s1_bot_y_r, s1_bot_z_r;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (out_adv) s1_valid_nxt = 1'b0;
    if (in_accept && obj_end) s1_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && obj_end) begin
      s1_empty_r <= in_no_points;
      s1_top_x_r <= top_x_nxt;
      s1_top_y_r <= top_y_nxt;
      s1_top_z_r <= top_z_nxt;
      s1_bot_x_r <= bot_x_nxt;
      s1_bot_y_r <= bot_y_nxt;
      s1_bot_z_r <= bot_z_nxt;
    end
  end

  // Face code of one endpoint; z overrides y, y overrides x
  function automatic face_t face_code(input coord_t px, input coord_t py, input coord_t pz,
                                      input reg_t w, input reg_t h, input reg_t l,
                                      input reg_t xm, input reg_t ym, input reg_t zm);
    face_t code;
    cmp_t  ex, ey, ez;
    cmp_t  ew, eh, el, exm, eym, ezm;
    ex  = CMP_W'(px);
    ey  = CMP_W'(py);
    ez  = CMP_W'(pz);
    ew  = cmp_t'(CMP_W'(w));
    eh  = cmp_t'(CMP_W'(h));
    el  = cmp_t'(CMP_W'(l));
    exm = cmp_t'(CMP_W'(xm));
    eym = cmp_t'(CMP_W'(ym));
    ezm = cmp_t'(CMP_W'(zm));
    code = '0;
    if (ew - ex < exm)      code[FACE_X_HI] = 1'b1;
    else if (ex < exm)      code[FACE_X_LO] = 1'b1;
    if (eh - ey < eym)      code = face_t'(1) << FACE_Y_HI;
    else if (eh + ey < eym) code = face_t'(1) << FACE_Y_LO;
    if (el - ez < ezm)      code = face_t'(1) << FACE_Z_HI;
    else if (ez < ezm)      code = face_t'(1) << FACE_Z_LO;
    return code;
  endfunction

  // Stage 2: classify into the output register
  face_t   top_face, bot_face;
  result_t res;

  always_comb begin
    top_face = face_code(s1_top_x_r, s1_top_y_r, s1_top_z_r,
                         det_width_r, det_half_height_r, det_length_r,
                         x_margin_r, y_margin_r, z_margin_r);
    bot_face = face_code(s1_bot_x_r, s1_bot_y_r, s1_bot_z_r,
                         det_width_r, det_half_height_r, det_length_r,
                         x_margin_r, y_margin_r, z_margin_r);
    res = classify(top_face | bot_face);
    if (s1_empty_r) begin
      res.tag   = TAG_NONE;
      res.score = SCORE_NONE;
    end
  end

  tag_t   out_tag_r;
  score_t out_score_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_adv) out_valid_nxt = s1_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && s1_valid_r) begin
      out_tag_r   <= res.tag;
      out_score_r <= res.score;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_tag_code     = out_tag_r;
  assign out_score_tenths = out_score_r;

`ifndef NO_ASSERTIONS
  // input only backs up when stage 1 is full and the output is blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("in_stall without a blocked stage");

  // an ending transaction leaves no point pending
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && obj_end) |=> (!have_point_r && s1_valid_r))
    else $error("object end did not clear tracker or load stage 1");

  // a pending object always has its top at or above its bottom
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    have_point_r |-> (top_y_r >= bot_y_r))
    else $error("top endpoint below bottom endpoint");

  // score and tag agree
  a_score_tag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_score_r == SCORE_NONE) == (out_tag_r == TAG_NONE)) &&
                    ((out_score_r == SCORE_ZZ) == (out_tag_r == TAG_ZZ)))
    else $error("score does not match tag");

  // a stage-1 result reaches the output once the output frees up
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_adv) |=> out_valid_r)
    else $error("stage 1 result lost");
`endif

endmodule

// ===== tb/sv/tb_track_boundary_cosmic_tagger.sv =====
// Testbench for track_boundary_cosmic_tagger: directed objects, register extremes,
// random geometry with random idling, and output backpressure, checked against a
// local endpoint tracker. Depends on tbct_pkg and the tagger RTL.
`timescale 1ns / 1ps

module tb_track_boundary_cosmic_tagger;
  import tbct_pkg::*;

  localparam int COORD_BITS  = 20;
  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE_CYC  = 4;
  localparam reg_t REG_MAX   = 19'h7FFFF;

  // Indexes past the register list; writes there are dropped
  localparam cfg_idx_t CFG_IDX_SPARE_LO = 3'd6;
  localparam cfg_idx_t CFG_IDX_SPARE_HI = 3'd7;

  // Face bits of one endpoint, one nibble per axis
  localparam logic [11:0] FM_X_HI   = 12'h001;
  localparam logic [11:0] FM_X_LO   = 12'h002;
  localparam logic [11:0] FM_Y_HI   = 12'h010;
  localparam logic [11:0] FM_Y_LO   = 12'h020;
  localparam logic [11:0] FM_Z_HI   = 12'h100;
  localparam logic [11:0] FM_Z_LO   = 12'h200;
  localparam logic [11:0] FM_X_BOTH = FM_X_HI | FM_X_LO;
  localparam logic [11:0] FM_Y_BOTH = FM_Y_HI | FM_Y_LO;
  localparam logic [11:0] FM_Z_BOTH = FM_Z_HI | FM_Z_LO;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   in_valid = 1'b0;
  logic   in_stall;
  coord_t in_point_x = '0;
  coord_t in_point_y = '0;
  coord_t in_point_z = '0;
  logic   in_last_point = 1'b0;
  logic   in_no_points = 1'b0;
  logic   out_valid;
  logic   out_stall = 1'b0;
  tag_t   out_tag_code;
  score_t out_score_tenths;
  logic     cfg_we = 1'b0;
  cfg_idx_t cfg_index = '0;
  reg_t     cfg_wdata = '0;

  track_boundary_cosmic_tagger #(.COORD_BITS(COORD_BITS)) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_point_x       (in_point_x),
    .in_point_y       (in_point_y),
    .in_point_z       (in_point_z),
    .in_last_point    (in_last_point),
    .in_no_points     (in_no_points),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_tag_code     (out_tag_code),
    .out_score_tenths (out_score_tenths),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  // Tracker state and geometry shadow
  reg_t    geom [0:5];
  coord_t  top_x, top_y, top_z;
  coord_t  bot_x, bot_y, bot_z;
  bit      have_pt;
  result_t expected_tags [$];

  int send_gap_pct = 20;
  int recv_stall_pct = 20;
  int hold_left = 0;
  int items_sent = 0;
  int fail_count = 0;
  int cycle_count = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  // Face code of one endpoint; a later axis overwrites an earlier one
  function automatic logic [11:0] endpoint_faces(coord_t x, coord_t y, coord_t z);
    longint w, h, l, xm, ym, zm;
    logic [11:0] code;
    w  = longint'(geom[CFG_DET_WIDTH]);
    h  = longint'(geom[CFG_DET_HALF_HEIGHT]);
    l  = longint'(geom[CFG_DET_LENGTH]);
    xm = longint'(geom[CFG_X_MARGIN]);
    ym = longint'(geom[CFG_Y_MARGIN]);
    zm = longint'(geom[CFG_Z_MARGIN]);
    code = '0;
    if (w - longint'(x) < xm) code = FM_X_HI;
    else if (longint'(x) < xm) code = FM_X_LO;
    if (h - longint'(y) < ym) code = FM_Y_HI;
    else if (h + longint'(y) < ym) code = FM_Y_LO;
    if (l - longint'(z) < zm) code = FM_Z_HI;
    else if (longint'(z) < zm) code = FM_Z_LO;
    return code;
  endfunction

  function automatic result_t tag_from_faces(logic [11:0] m);
    result_t res;
    res.tag   = TAG_NONE;
    res.score = SCORE_NONE;
    if ($countones(m) > 1) begin
      if ((m & FM_Z_BOTH) != FM_Z_BOTH) begin
        res.score = SCORE_PAIR;
        if ((m & FM_X_BOTH) == FM_X_BOTH) res.tag = TAG_XX;
        else if ((m & FM_Y_BOTH) == FM_Y_BOTH) res.tag = TAG_YY;
        else if ((m & FM_X_BOTH) != 0 && (m & FM_Y_BOTH) != 0) res.tag = TAG_XY;
        else if ((m & FM_X_BOTH) != 0 && (m & FM_Z_BOTH) != 0) res.tag = TAG_XZ;
        else res.tag = TAG_YZ;
      end else begin
        res.tag   = TAG_ZZ;
        res.score = SCORE_ZZ;
      end
    end else if ($countones(m) == 1) begin
      res.score = SCORE_SINGLE;
      if ((m & FM_X_BOTH) != 0) res.tag = TAG_X;
      else if ((m & FM_Y_BOTH) != 0) res.tag = TAG_Y;
      else res.tag = TAG_Z;
    end
    return res;
  endfunction

  // Update top/bottom endpoints for one accepted point; queue the tag if it closes
  function automatic void track_endpoints(coord_t x, coord_t y, coord_t z,
                                          bit is_last, bit is_empty);
    result_t res;
    if (is_empty) begin
      have_pt   = 1'b0;
      res.tag   = TAG_NONE;
      res.score = SCORE_NONE;
      expected_tags = {expected_tags, res};
      return;
    end
    if (!have_pt) begin
      top_x = x; top_y = y; top_z = z;
      bot_x = x; bot_y = y; bot_z = z;
      have_pt = 1'b1;
    end else begin
      // strict compares: on a tie the first point stays
      if (y > top_y) begin
        top_x = x; top_y = y; top_z = z;
      end
      if (y < bot_y) begin
        bot_x = x; bot_y = y; bot_z = z;
      end
    end
    if (is_last) begin
      res = tag_from_faces(endpoint_faces(top_x, top_y, top_z) |
                           endpoint_faces(bot_x, bot_y, bot_z));
      expected_tags = {expected_tags, res};
      have_pt = 1'b0;
    end
  endfunction

  // One input transaction, with random idle cycles ahead of it
  task automatic send_point(input coord_t x, input coord_t y, input coord_t z,
                            input bit is_last, input bit is_empty);
    while ($urandom_range(99) < send_gap_pct) begin
      @(negedge clk);
      in_valid      <= 1'b0;
      in_point_x    <= coord_t'($urandom);
      in_point_y    <= coord_t'($urandom);
      in_point_z    <= coord_t'($urandom);
      in_last_point <= 1'($urandom_range(1));
      in_no_points  <= 1'($urandom_range(1));
      @(posedge clk);
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    in_point_x    <= x;
    in_point_y    <= y;
    in_point_z    <= z;
    in_last_point <= is_last;
    in_no_points  <= is_empty;
    do @(posedge clk); while (in_stall !== 1'b0);
    track_endpoints(x, y, z, is_last, is_empty);
    items_sent++;
  endtask

  // Stop sending and wait until every queued tag has come back
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_tags.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input reg_t val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx <= CFG_Z_MARGIN) geom[idx] = val;
  endtask

  task automatic write_geometry(input reg_t w, input reg_t h, input reg_t l,
                                input reg_t xm, input reg_t ym, input reg_t zm);
    write_reg(CFG_DET_WIDTH, w);
    write_reg(CFG_DET_HALF_HEIGHT, h);
    write_reg(CFG_DET_LENGTH, l);
    write_reg(CFG_X_MARGIN, xm);
    write_reg(CFG_Y_MARGIN, ym);
    write_reg(CFG_Z_MARGIN, zm);
  endtask

  function automatic coord_t coord_around(longint face, reg_t spread);
    longint off;
    off = longint'($urandom_range(0, 2 * spread + 8)) - longint'(spread) - 4;
    return coord_t'(face + off);
  endfunction

  // Coordinate biased toward the two faces of one axis
  function automatic coord_t pick_coord(longint lo_face, longint hi_face, reg_t margin);
    case ($urandom_range(3))
      0: return coord_t'($urandom);
      1: return coord_around(lo_face, margin);
      2: return coord_around(hi_face, margin);
      default: return coord_around((lo_face + hi_face) / 2, reg_t'((hi_face - lo_face) / 2));
    endcase
  endfunction

  // Random object; now and then it is cut short by an empty marker
  task automatic send_random_object(input int unsigned max_pts);
    int unsigned npts;
    coord_t x, y, z, prev_y;
    npts = $urandom_range(1, max_pts);
    prev_y = '0;
    for (int unsigned i = 0; i < npts; i++) begin
      x = pick_coord(0, longint'(geom[CFG_DET_WIDTH]), geom[CFG_X_MARGIN]);
      y = pick_coord(-longint'(geom[CFG_DET_HALF_HEIGHT]),
                     longint'(geom[CFG_DET_HALF_HEIGHT]), geom[CFG_Y_MARGIN]);
      z = pick_coord(0, longint'(geom[CFG_DET_LENGTH]), geom[CFG_Z_MARGIN]);
      if (i > 0 && $urandom_range(7) == 0) y = prev_y;
      prev_y = y;
      if (i == npts - 1) begin
        if ($urandom_range(19) == 0) send_point(x, y, z, 1'($urandom_range(1)), 1'b1);
        else send_point(x, y, z, 1'b1, 1'b0);
      end else if ($urandom_range(29) == 0) begin
        send_point(x, y, z, 1'($urandom_range(1)), 1'b1);
      end else begin
        send_point(x, y, z, 1'b0, 1'b0);
      end
    end
  endtask

  // Hand-built objects at reset geometry: every tag but TAG_Y, ties, empties, extremes
  task automatic test_directed_cases();
    send_point(8000, 0, 30000, 1, 0);
    send_point(16300, 0, 30000, 1, 0);
    send_point(100, 0, 30000, 1, 0);
    send_point(8000, 7400, 30000, 0, 0);
    send_point(8000, -7400, 30000, 1, 0);
    send_point(8000, 7400, 66300, 0, 0);
    send_point(8000, -7400, 10, 1, 0);
    send_point(16300, 0, 30000, 0, 0);
    send_point(8000, 7400, 30000, 1, 0);
    send_point(16300, 5, 30000, 0, 0);
    send_point(8000, 0, 66300, 1, 0);
    send_point(8000, 7400, 30000, 0, 0);
    send_point(8000, 0, 10, 1, 0);
    send_point(16300, 100, 30000, 0, 0);
    send_point(100, -100, 30000, 1, 0);
    // z contact overrides y contact on the same endpoint
    send_point(8000, 7400, 10, 1, 0);
    // equal y: the first point stays top and bottom
    send_point(8000, 500, 30000, 0, 0);
    send_point(16300, 500, 30000, 0, 0);
    send_point(100, 500, 30000, 1, 0);
    // empty marker drops the gathered point
    send_point(16300, 0, 30000, 0, 0);
    send_point(0, 0, 0, 0, 1);
    send_point(8000, 0, 30000, 1, 0);
    send_point(-1, -1, -1, 1, 1);
    send_point(-524288, -524288, -524288, 0, 0);
    send_point(524287, 524287, 524287, 1, 0);
    send_point(0, 0, 0, 1, 0);
    drain_results();
  endtask

  task automatic run_objects(input int n_objs, input int unsigned max_pts);
    repeat (n_objs) send_random_object(max_pts);
    drain_results();
  endtask

  // Zero and full-scale geometry, plus writes to unused indexes
  task automatic test_register_extremes();
    write_geometry('0, '0, '0, '0, '0, '0);
    run_objects(25, 4);
    write_geometry(REG_MAX, REG_MAX, REG_MAX, REG_MAX, REG_MAX, REG_MAX);
    run_objects(25, 4);
    write_geometry(REG_MAX, REG_MAX, REG_MAX, '0, '0, '0);
    write_reg(CFG_IDX_SPARE_LO, reg_t'($urandom));
    write_reg(CFG_IDX_SPARE_HI, reg_t'($urandom));
    run_objects(25, 4);
    write_geometry('0, '0, '0, REG_MAX, REG_MAX, REG_MAX);
    run_objects(25, 4);
  endtask

  // Random geometry per phase; phase 1 runs with no idling on either side
  task automatic test_random_geometry();
    int phase_start;
    for (int phase = 0; phase < 4; phase++) begin
      write_geometry(reg_t'($urandom_range(1000, 40000)), reg_t'($urandom_range(500, 20000)),
                     reg_t'($urandom_range(1000, 200000)), reg_t'($urandom_range(0, 2000)),
                     reg_t'($urandom_range(0, 2000)), reg_t'($urandom_range(0, 2000)));
      if (phase == 1) begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end
      phase_start = items_sent;
      while (items_sent - phase_start < 240) begin
        send_random_object(6);
        // occasional pause until all tags are back
        if ($urandom_range(49) == 0) drain_results();
      end
      drain_results();
      send_gap_pct   = 20;
      recv_stall_pct = 20;
    end
  endtask

  // Receiver holds off while single-point objects keep coming, filling the block
  task automatic test_output_backpressure();
    send_gap_pct = 0;
    hold_left = 150;
    repeat (50) send_random_object(1);
    drain_results();
    send_gap_pct = 20;
  endtask

  // Receiver stall; long hold-off counted here
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Result checker: each accepted transaction against the oldest expected tag
  always @(posedge clk) begin
    result_t exp_res;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (expected_tags.size() == 0) begin
        $error("unexpected result: tag_code %0d score_tenths %0d",
               out_tag_code, out_score_tenths);
        fail_count++;
      end else begin
        exp_res = expected_tags.pop_front();
        if (out_tag_code !== exp_res.tag) begin
          $error("tag_code mismatch: expected %0d, actual %0d", exp_res.tag, out_tag_code);
          fail_count++;
        end
        if (out_score_tenths !== exp_res.score) begin
          $error("score_tenths mismatch: expected %0d, actual %0d",
                 exp_res.score, out_score_tenths);
          fail_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("track_boundary_cosmic_tagger verification failed");
      $finish;
    end
  end

  initial begin
    geom[CFG_DET_WIDTH]       = RST_DET_WIDTH;
    geom[CFG_DET_HALF_HEIGHT] = RST_DET_HALF_HEIGHT;
    geom[CFG_DET_LENGTH]      = RST_DET_LENGTH;
    geom[CFG_X_MARGIN]        = RST_MARGIN;
    geom[CFG_Y_MARGIN]        = RST_MARGIN;
    geom[CFG_Z_MARGIN]        = RST_MARGIN;
    have_pt = 1'b0;
    top_x = '0; top_y = '0; top_z = '0;
    bot_x = '0; bot_y = '0; bot_z = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_register_extremes();
    test_random_geometry();
    test_output_backpressure();

    drain_results();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("track_boundary_cosmic_tagger verification clean");
    end else begin
      $display("track_boundary_cosmic_tagger verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/tbct_pkg.sv
design/track_boundary_cosmic_tagger.sv
tb/sv/tb_track_boundary_cosmic_tagger.sv
